>>> rtl/core/sst_pkg.sv
// Types, character codes and helpers for the shell-style tokenizer.
// Used by shell_style_tokenizer; depends on nothing else.
package sst_pkg;

    // Kind of one emitted result
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TOKEND  = 2'd1,
        KIND_LINEEND = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // Error reported at a line end
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SQUOTE = 2'd1,
        ERR_DQUOTE = 2'd2,
        ERR_ESCAPE = 2'd3
    } t_err;

    // Scanner mode; code 7 is unused, drops its byte and returns to blank
    typedef enum logic [2:0] {
        MODE_BLANK   = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_SQ      = 3'd2,
        MODE_DQ      = 3'd3,
        MODE_DQ_BS   = 3'd4,
        MODE_ESC     = 3'd5,
        MODE_COMMENT = 3'd6
    } t_mode;

    // One queued result
    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        t_err       error_code;
        logic       last;
    } t_result;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Result queue depth; room for two results is needed to take an item
    localparam int QUEUE_DEPTH = 3;

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [7:0] c,
                                            input t_err e);
        t_result r;
        r.kind       = k;
        r.char_out   = c;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/core/shell_style_tokenizer.sv
// Shell-style tokenizer: splits a byte stream into token bytes, token ends
// and line ends. Depends on sst_pkg.
//
// Usage:
//   Input channel (i_valid, o_stall, i_char_in) takes one byte per transfer.
//   Byte 0 or newline ends a line. Output channel (o_valid, i_stall, o_kind,
//   o_char_out, o_error_code, o_last) gives the results of each byte in
//   order; o_last marks the final result of a byte. A byte gives zero, one
//   or two results.
//   The scanner mode and the results of a byte are formed in the same cycle
//   the byte is taken and go into a three-entry result queue, whose head
//   drives the outputs.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver does not stall. A byte that gives two results holds the
//   output until both are taken, so the output port sets the rate then.
//   o_stall rises while fewer than two queue entries are free.
//   Stall: the queue head holds steady while i_stall is high; bytes keep
//   being taken while at least two queue entries are free.
//   Reset: synchronous, active low; empties the queue and returns the
//   scanner to the between-tokens mode.
module shell_style_tokenizer
    import sst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_out,
    output logic [1:0] o_error_code,
    output logic       o_last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_mode              r_mode, n_mode;
    t_result            r_queue [QUEUE_DEPTH];
    t_result            n_queue [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;

    logic               in_xfer, out_xfer;
    logic [1:0]         res_num;
    t_result            res0, res1;
    logic [CNT_W-1:0]   base;
    logic               eol;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;
    assign o_stall  = (r_count > CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid  = (r_count != '0);

    assign o_kind       = r_queue[0].kind;
    assign o_char_out   = r_queue[0].char_out;
    assign o_error_code = r_queue[0].error_code;
    assign o_last       = r_queue[0].last;

    assign eol = (i_char_in == CH_NUL) || (i_char_in == CH_NEWLINE);

    // Scan one byte: next mode and up to two results
    always_comb begin
        n_mode  = r_mode;
        res_num = 2'd0;
        res0    = make_result(KIND_BYTE, 8'h00, ERR_NONE);
        res1    = make_result(KIND_BYTE, 8'h00, ERR_NONE);
        if (eol) begin
            n_mode = MODE_BLANK;
            unique case (r_mode)
                MODE_WORD: begin
                    res0    = make_result(KIND_TOKEND, 8'h00, ERR_NONE);
                    res1    = make_result(KIND_LINEEND, 8'h00, ERR_NONE);
                    res_num = 2'd2;
                end
                MODE_SQ: begin
                    res0    = make_result(KIND_ERROR, 8'h00, ERR_SQUOTE);
                    res_num = 2'd1;
                end
                MODE_DQ, MODE_DQ_BS: begin
                    res0    = make_result(KIND_ERROR, 8'h00, ERR_DQUOTE);
                    res_num = 2'd1;
                end
                MODE_ESC: begin
                    res0    = make_result(KIND_ERROR, 8'h00, ERR_ESCAPE);
                    res_num = 2'd1;
                end
                default: begin
                    res0    = make_result(KIND_LINEEND, 8'h00, ERR_NONE);
                    res_num = 2'd1;
                end
            endcase
        end else begin
            unique case (r_mode)
                MODE_WORD, MODE_BLANK: begin
                    priority if (i_char_in == CH_SQUOTE) begin
                        n_mode = MODE_SQ;
                    end else if (i_char_in == CH_DQUOTE) begin
                        n_mode = MODE_DQ;
                    end else if (i_char_in == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (i_char_in == CH_HASH || is_blank(i_char_in)) begin
                        // End a running token; hash opens a comment
                        if (r_mode == MODE_WORD) begin
                            res0    = make_result(KIND_TOKEND, 8'h00, ERR_NONE);
                            res_num = 2'd1;
                        end
                        n_mode = (i_char_in == CH_HASH) ? MODE_COMMENT : MODE_BLANK;
                    end else begin
                        res0    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                        res_num = 2'd1;
                        n_mode  = MODE_WORD;
                    end
                end
                MODE_SQ: begin
                    if (i_char_in == CH_SQUOTE) begin
                        n_mode = MODE_WORD;
                    end else begin
                        res0    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                        res_num = 2'd1;
                    end
                end
                MODE_DQ: begin
                    priority if (i_char_in == CH_DQUOTE) begin
                        n_mode = MODE_WORD;
                    end else if (i_char_in == CH_BACKSLASH) begin
                        n_mode = MODE_DQ_BS;
                    end else begin
                        res0    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                        res_num = 2'd1;
                    end
                end
                MODE_DQ_BS: begin
                    // Only quote and backslash are escapes; keep other backslashes
                    n_mode = MODE_DQ;
                    if (i_char_in != CH_DQUOTE && i_char_in != CH_BACKSLASH) begin
                        res0    = make_result(KIND_BYTE, CH_BACKSLASH, ERR_NONE);
                        res1    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                        res_num = 2'd2;
                    end else begin
                        res0    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                        res_num = 2'd1;
                    end
                end
                MODE_ESC: begin
                    res0    = make_result(KIND_BYTE, i_char_in, ERR_NONE);
                    res_num = 2'd1;
                    n_mode  = MODE_WORD;
                end
                default: begin
                    // Comment and unused code: drop the byte
                    n_mode = (r_mode == MODE_COMMENT) ? MODE_COMMENT : MODE_BLANK;
                end
            endcase
        end
        // Mark the final result of this byte
        if (res_num == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    // Advance the queue: pop the head, append new results behind the rest
    always_comb begin
        base    = r_count - CNT_W'(out_xfer);
        n_queue = r_queue;
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (out_xfer) begin
                n_queue[j] = r_queue[j + 1];
            end
        end
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (in_xfer && (res_num != 2'd0) && (CNT_W'(j) == base)) begin
                n_queue[j] = res0;
            end
            if (in_xfer && (res_num == 2'd2) && (CNT_W'(j) == base + CNT_W'(1))) begin
                n_queue[j] = res1;
            end
        end
        n_count = base + (in_xfer ? CNT_W'(res_num) : '0);
    end

    // Hold control state under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BLANK;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_mode <= n_mode;
            end
        end
        r_queue <= n_queue;
    end

    // Queue never overflows
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A taken byte always leaves room for two results
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_count <= CNT_W'(QUEUE_DEPTH - 2)))
        else $error("byte taken without room");

    // Every line end returns the scanner to blank mode
    a_eol_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && eol) |=> (r_mode == MODE_BLANK))
        else $error("mode not cleared at line end");

    // Error code appears only on an error result
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == KIND_ERROR) == (o_error_code != ERR_NONE)))
        else $error("error code and kind disagree");

    // Line ends and errors close their byte
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_LINEEND || o_kind == KIND_ERROR)) |-> o_last)
        else $error("line end not marked last");

endmodule

>>> verif/shell_style_tokenizer_test.sv
`timescale 1ns / 100ps
// Self-checking bench for shell_style_tokenizer: directed lines, then random shell-like lines
// and noise under several idle and stall patterns. Depends on sst_pkg and the tokenizer RTL.
module shell_style_tokenizer_test;
    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] CH_VTAB = 8'h0B;
    localparam logic [7:0] CH_FFEED = 8'h0C;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_in;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_kind;
    logic [7:0] o_char_out;
    logic [1:0] o_error_code;
    logic       o_last;

    // Lexer outputs still due from the block, oldest first
    t_result lexed_due[$];
    t_result head_lexeme;
    t_mode   lex_mode = MODE_BLANK;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int token_ends_seen = 0;
    int line_errors_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    shell_style_tokenizer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_char_out   (o_char_out),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_sep_char(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void add_lexeme(input t_kind k, input logic [7:0] ch, input t_err e);
        t_result r;
        r.kind       = k;
        r.char_out   = ch;
        r.error_code = e;
        r.last       = 1'b0;
        lexed_due.push_back(r);
    endfunction

    // Advance the lexer by one byte and queue the outputs it gives
    function automatic void lex_byte(input logic [7:0] c);
        int      first;
        t_mode   next_mode;
        t_result tail;
        first = lexed_due.size();
        next_mode = lex_mode;
        if (c == CH_NUL || c == CH_NEWLINE) begin
            case (lex_mode)
                MODE_WORD: begin
                    add_lexeme(KIND_TOKEND, 8'h00, ERR_NONE);
                    add_lexeme(KIND_LINEEND, 8'h00, ERR_NONE);
                end
                MODE_SQ:              add_lexeme(KIND_ERROR, 8'h00, ERR_SQUOTE);
                MODE_DQ, MODE_DQ_BS:  add_lexeme(KIND_ERROR, 8'h00, ERR_DQUOTE);
                MODE_ESC:             add_lexeme(KIND_ERROR, 8'h00, ERR_ESCAPE);
                default:              add_lexeme(KIND_LINEEND, 8'h00, ERR_NONE);
            endcase
            next_mode = MODE_BLANK;
        end else begin
            case (lex_mode)
                MODE_SQ: begin
                    if (c == CH_SQUOTE) next_mode = MODE_WORD;
                    else add_lexeme(KIND_BYTE, c, ERR_NONE);
                end
                MODE_DQ: begin
                    if (c == CH_DQUOTE) next_mode = MODE_WORD;
                    else if (c == CH_BACKSLASH) next_mode = MODE_DQ_BS;
                    else add_lexeme(KIND_BYTE, c, ERR_NONE);
                end
                MODE_DQ_BS: begin
                    // only \" and \\ are escapes; keep the backslash otherwise
                    if (c != CH_DQUOTE && c != CH_BACKSLASH)
                        add_lexeme(KIND_BYTE, CH_BACKSLASH, ERR_NONE);
                    add_lexeme(KIND_BYTE, c, ERR_NONE);
                    next_mode = MODE_DQ;
                end
                MODE_ESC: begin
                    add_lexeme(KIND_BYTE, c, ERR_NONE);
                    next_mode = MODE_WORD;
                end
                MODE_COMMENT: ;
                default: begin
                    // between tokens or inside an unquoted token
                    if (c == CH_SQUOTE) begin
                        next_mode = MODE_SQ;
                    end else if (c == CH_DQUOTE) begin
                        next_mode = MODE_DQ;
                    end else if (c == CH_BACKSLASH) begin
                        next_mode = MODE_ESC;
                    end else if (c == CH_HASH || is_sep_char(c)) begin
                        if (lex_mode == MODE_WORD) add_lexeme(KIND_TOKEND, 8'h00, ERR_NONE);
                        next_mode = (c == CH_HASH) ? MODE_COMMENT : MODE_BLANK;
                    end else begin
                        add_lexeme(KIND_BYTE, c, ERR_NONE);
                        next_mode = MODE_WORD;
                    end
                end
            endcase
        end
        lex_mode = next_mode;
        // mark the final output of this byte
        if (lexed_due.size() > first) begin
            tail = lexed_due.pop_back();
            tail.last = 1'b1;
            lexed_due.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Send one byte: starts and returns at a falling edge
    task automatic push_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (o_stall);
        lex_byte(c);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_NEWLINE || is_sep_char(c) || c == CH_SQUOTE || c == CH_DQUOTE ||
               c == CH_BACKSLASH || c == CH_HASH);
        return c;
    endfunction

    // Any byte that keeps the line open and does not close the given quote
    function automatic logic [7:0] literal_char(input logic [7:0] closer);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_NEWLINE || c == closer ||
               (closer == CH_DQUOTE && c == CH_BACKSLASH));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VTAB;
            3:       return CH_FFEED;
            default: return CH_CR;
        endcase
    endfunction

    // One shell-like line with random content, sometimes left open at the end
    task automatic send_shell_line();
        int n_words;
        n_words = $urandom_range(0, 4);
        for (int w = 0; w < n_words; w++) begin
            if (w > 0 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) push_char(blank_char());
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, 4)) push_char(plain_char());
                1: begin
                    push_char(CH_SQUOTE);
                    repeat ($urandom_range(0, 3)) push_char(literal_char(CH_SQUOTE));
                    push_char(CH_SQUOTE);
                end
                2: begin
                    push_char(CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                push_char(CH_BACKSLASH);
                                push_char($urandom_range(0, 1) ? CH_DQUOTE : CH_BACKSLASH);
                            end
                            1: begin
                                push_char(CH_BACKSLASH);
                                push_char(literal_char(CH_DQUOTE));
                            end
                            default: push_char(literal_char(CH_DQUOTE));
                        endcase
                    end
                    push_char(CH_DQUOTE);
                end
                3: begin
                    push_char(CH_BACKSLASH);
                    push_char(literal_char(CH_NUL));
                    repeat ($urandom_range(0, 2)) push_char(plain_char());
                end
                4: begin
                    // word glued to a quoted part, then a comment
                    push_char(plain_char());
                    push_char(CH_SQUOTE);
                    push_char(literal_char(CH_SQUOTE));
                    push_char(CH_SQUOTE);
                    push_char(CH_HASH);
                end
                default: begin
                    push_char(CH_HASH);
                    repeat ($urandom_range(0, 5)) push_char(literal_char(CH_NUL));
                end
            endcase
        end
        // leave a quote or escape open now and then
        case ($urandom_range(0, 9))
            0: push_char(CH_SQUOTE);
            1: push_char(CH_DQUOTE);
            2: push_char(CH_BACKSLASH);
            3: begin
                push_char(CH_DQUOTE);
                push_char(CH_BACKSLASH);
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) push_char(blank_char());
        push_char($urandom_range(0, 1) ? CH_NEWLINE : CH_NUL);
    endtask

    task automatic send_noise_bytes();
        repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
    endtask

    // High byte, hash ending a token, comment, escaped hash, escape open at line end
    task automatic test_words_and_comments();
        push_char(8'hFF);
        push_text("#c");
        push_char(CH_NEWLINE);
        push_text("\\#\\");
        push_char(CH_NEWLINE);
    endtask

    // Empty quotes, tab separator, all double-quote escapes, line end inside a token
    task automatic test_quoting();
        push_text("''\t\"\\q\\\"\\\\\"z");
        push_char(CH_NUL);
    endtask

    // Line ends inside single quotes and after a backslash in double quotes
    task automatic test_open_quotes();
        push_text("'a");
        push_char(CH_NUL);
        push_text("\"\\");
        push_char(CH_NEWLINE);
    endtask

    task automatic test_random_lines(input int send_pct, input int stall_pct, input int n_chars);
        int stop_at;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) send_noise_bytes();
            else send_shell_line();
        end
    endtask

    // Random receiver stall, changed at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Compare each transfer on the output with the oldest due lexeme
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (lexed_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d char %0h err %0d last %0d",
                         $time, o_kind, o_char_out, o_error_code, o_last);
                mismatches++;
            end else begin
                head_lexeme = lexed_due.pop_front();
                check_field("kind", head_lexeme.kind, o_kind);
                check_field("char_out", head_lexeme.char_out, o_char_out);
                check_field("error_code", head_lexeme.error_code, o_error_code);
                check_field("last", head_lexeme.last, o_last);
                results_checked++;
                if (head_lexeme.kind == KIND_TOKEND) token_ends_seen++;
                if (head_lexeme.kind == KIND_ERROR) line_errors_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, lexed_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_char_in = 8'h00;
        i_stall   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_words_and_comments();
        test_quoting();
        test_open_quotes();

        // no idling, idle sender, stalling receiver, then both
        test_random_lines(0, 0, 390);
        test_random_lines(62, 0, 390);
        test_random_lines(0, 62, 390);
        test_random_lines(15, 15, 390);

        i_valid <= 1'b0;
        while (lexed_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes, checked %0d results: %0d token ends, %0d line errors.",
                 chars_sent, results_checked, token_ends_seen, line_errors_seen);
        $display("%0d mismatches over idle, stall and mixed traffic phases.", mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sst_pkg.sv
rtl/core/shell_style_tokenizer.sv
verif/shell_style_tokenizer_test.sv
